### hdl/quoted_string_unescape_utf8_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef QUOTED_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH
`define QUOTED_STRING_UNESCAPE_UTF8_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, ignored while reset is asserted.
`define QSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, ignored while reset is asserted.
`define QSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/qsu_pkg.sv
`default_nettype none

package qsu_pkg;

	typedef enum logic [1:0] {
		STATUS_DATA   = 2'd0,
		STATUS_CLOSED = 2'd1,
		STATUS_ERROR  = 2'd2
	} status_t;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_UNTERM_STR   = 3'd1;
	localparam logic [2:0] ERR_UNTERM_ESC   = 3'd2;
	localparam logic [2:0] ERR_BAD_ESC      = 3'd3;
	localparam logic [2:0] ERR_TRUNC_UNI    = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd5;

	// Text bytes that open, close or interrupt a string.
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Characters that may follow a backslash in a basic string.
	localparam logic [7:0] ESC_N     = 8'h6E;
	localparam logic [7:0] ESC_T     = 8'h74;
	localparam logic [7:0] ESC_R     = 8'h72;
	localparam logic [7:0] ESC_B     = 8'h62;
	localparam logic [7:0] ESC_F     = 8'h66;
	localparam logic [7:0] ESC_ZERO  = 8'h30;
	localparam logic [7:0] ESC_U4    = 8'h75;
	localparam logic [7:0] ESC_U8    = 8'h55;

	// One queue entry: all words caused by one input word.
	typedef struct packed {
		logic [3:0][7:0] data;
		logic [1:0]      last_idx;
		status_t         status;
		logic [2:0]      err;
	} entry_t;

endpackage

`default_nettype wire

### hdl/quoted_string_unescape_utf8_unit.sv
// Results of an accepted s_axis word are queued; m_axis shows the queue head.
// Throughput: one input and, while m_axis_tready is high, one output word per cycle. The final hex digit
// of a \u or \U escape yields up to four words, drained at one per cycle through a
// QUEUE_DEPTH-entry queue; s_axis_tready drops only while that queue is full.
// Reset (arst_n low, asynchronous): idle, escape state and queue cleared at once.
`default_nettype none

module quoted_string_unescape_utf8_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	input  wire logic        s_axis_tlast,   // end_of_text
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [10:8] error_code
	output logic [1:0]       m_axis_tuser,   // [1:0] status
	output logic             m_axis_tlast    // last
);

	logic            push, pop, full, not_empty;
	qsu_pkg::entry_t push_entry, head;

	assign s_axis_tready = !full;

	qsu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.text_byte   (s_axis_tdata),
		.end_of_text (s_axis_tlast),
		.push        (push),
		.push_entry  (push_entry)
	);

	qsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.full       (full),
		.not_empty  (not_empty),
		.head       (head)
	);

	qsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_user   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

endmodule

`default_nettype wire

### hdl/qsu_front.sv
`default_nettype none

module qsu_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           in_ready,
	input  wire logic [7:0]     text_byte,
	input  wire logic           end_of_text,
	output logic                push,
	output qsu_pkg::entry_t     push_entry
);

	typedef enum logic [4:0] {
		MODE_IDLE    = 5'b00001,
		MODE_LITERAL = 5'b00010,
		MODE_BASIC   = 5'b00100,
		MODE_ESC     = 5'b01000,
		MODE_HEX     = 5'b10000
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [3:0]  hex_left_q, hex_left_d;
	logic [31:0] code_point_q, code_point_d;
	logic        take;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [31:0] cp_next;
	qsu_pkg::entry_t ent;
	logic        produce;

	assign take = in_valid && in_ready;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
			hex_val = text_byte[3:0];
		end else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
			(text_byte >= 8'h41 && text_byte <= 8'h46)) begin
			hex_val = text_byte[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign cp_next = {code_point_q[27:0], hex_val};

	always_comb begin
		mode_d       = mode_q;
		hex_left_d   = hex_left_q;
		code_point_d = code_point_q;
		produce      = 1'b0;
		ent          = '0;
		ent.status   = qsu_pkg::STATUS_DATA;
		unique case (mode_q) inside
			MODE_LITERAL, MODE_BASIC: begin
				produce = 1'b1;
				if (end_of_text || text_byte == qsu_pkg::CH_LF) begin
					ent.status   = qsu_pkg::STATUS_ERROR;
					ent.err      = qsu_pkg::ERR_UNTERM_STR;
					mode_d       = MODE_IDLE;
					hex_left_d   = 4'd0;
					code_point_d = 32'd0;
				end else if ((mode_q == MODE_LITERAL && text_byte == qsu_pkg::CH_SQUOTE) ||
					(mode_q == MODE_BASIC && text_byte == qsu_pkg::CH_DQUOTE)) begin
					ent.status = qsu_pkg::STATUS_CLOSED;
					mode_d     = MODE_IDLE;
				end else if (mode_q == MODE_BASIC && text_byte == qsu_pkg::CH_BSLASH) begin
					produce = 1'b0;
					mode_d  = MODE_ESC;
				end else begin
					ent.data[0] = text_byte;
				end
			end
			MODE_ESC: begin
				produce = 1'b1;
				mode_d  = MODE_BASIC;
				if (end_of_text) begin
					ent.status   = qsu_pkg::STATUS_ERROR;
					ent.err      = qsu_pkg::ERR_UNTERM_ESC;
					mode_d       = MODE_IDLE;
					hex_left_d   = 4'd0;
					code_point_d = 32'd0;
				end else begin
					case (text_byte) inside
						qsu_pkg::CH_DQUOTE: ent.data[0] = qsu_pkg::CH_DQUOTE;
						qsu_pkg::CH_BSLASH: ent.data[0] = qsu_pkg::CH_BSLASH;
						qsu_pkg::ESC_N:     ent.data[0] = 8'h0A;
						qsu_pkg::ESC_T:     ent.data[0] = 8'h09;
						qsu_pkg::ESC_R:     ent.data[0] = 8'h0D;
						qsu_pkg::ESC_B:     ent.data[0] = 8'h08;
						qsu_pkg::ESC_F:     ent.data[0] = 8'h0C;
						qsu_pkg::ESC_ZERO:  ent.data[0] = 8'h00;
						qsu_pkg::ESC_U4, qsu_pkg::ESC_U8: begin
							produce      = 1'b0;
							mode_d       = MODE_HEX;
							hex_left_d   = text_byte[5] ? 4'd4 : 4'd8;
							code_point_d = 32'd0;
						end
						default: begin
							ent.status   = qsu_pkg::STATUS_ERROR;
							ent.err      = qsu_pkg::ERR_BAD_ESC;
							mode_d       = MODE_IDLE;
							hex_left_d   = 4'd0;
							code_point_d = 32'd0;
						end
					endcase
				end
			end
			MODE_HEX: begin
				if (end_of_text || !hex_ok) begin
					produce      = 1'b1;
					ent.status   = qsu_pkg::STATUS_ERROR;
					ent.err      = end_of_text ? qsu_pkg::ERR_TRUNC_UNI
					                           : qsu_pkg::ERR_BAD_HEX;
					mode_d       = MODE_IDLE;
					hex_left_d   = 4'd0;
					code_point_d = 32'd0;
				end else begin
					code_point_d = cp_next;
					hex_left_d   = hex_left_q - 4'd1;
					if (hex_left_q == 4'd1) begin
						produce = 1'b1;
						mode_d  = MODE_BASIC;
						// UTF-8 words are stored in output order, lowest index first.
						if (cp_next < 32'h80) begin
							ent.data[0]  = cp_next[7:0];
							ent.last_idx = 2'd0;
						end else if (cp_next < 32'h800) begin
							ent.data[0]  = 8'hC0 | {3'b000, cp_next[10:6]};
							ent.data[1]  = {2'b10, cp_next[5:0]};
							ent.last_idx = 2'd1;
						end else if (cp_next < 32'h10000) begin
							ent.data[0]  = 8'hE0 | {4'b0000, cp_next[15:12]};
							ent.data[1]  = {2'b10, cp_next[11:6]};
							ent.data[2]  = {2'b10, cp_next[5:0]};
							ent.last_idx = 2'd2;
						end else begin
							// Out-of-range code points keep the truncated 4-byte form.
							ent.data[0]  = 8'hF0 | cp_next[25:18];
							ent.data[1]  = {2'b10, cp_next[17:12]};
							ent.data[2]  = {2'b10, cp_next[11:6]};
							ent.data[3]  = {2'b10, cp_next[5:0]};
							ent.last_idx = 2'd3;
						end
					end
				end
			end
			default: begin
				if (!end_of_text) begin
					mode_d       = (text_byte == qsu_pkg::CH_SQUOTE) ? MODE_LITERAL : MODE_BASIC;
					hex_left_d   = 4'd0;
					code_point_d = 32'd0;
				end
			end
		endcase
	end

	assign push       = take && produce;
	assign push_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hex_left_q   <= 4'd0;
			code_point_q <= 32'd0;
		end else if (take) begin
			mode_q       <= mode_d;
			hex_left_q   <= hex_left_d;
			code_point_q <= code_point_d;
		end
	end

endmodule

`default_nettype wire

### hdl/qsu_queue.sv
`default_nettype none

module qsu_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire qsu_pkg::entry_t push_entry,
	input  wire logic            pop,
	output logic                 full,
	output logic                 not_empty,
	output qsu_pkg::entry_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qsu_pkg::entry_t slot_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

### hdl/qsu_back.sv
`default_nettype none

module qsu_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire qsu_pkg::entry_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [15:0]          out_data,
	output logic [1:0]           out_user,
	output logic                 out_last
);

	logic [1:0] idx_q;
	logic       fire;

	assign out_valid = head_valid;
	assign fire      = out_valid && out_ready;
	assign out_last  = (idx_q == head.last_idx);
	assign pop       = fire && out_last;
	assign out_data  = {5'b00000, head.err, head.data[idx_q]};
	assign out_user  = head.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (fire) begin
			idx_q <= out_last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

`default_nettype wire

### hdl/qsu_checker.sv
`default_nettype none
`include "quoted_string_unescape_utf8_unit_macros.svh"

module qsu_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast
);

	// A closing or error word is always the only word of its input.
	`QSU_ASSERT_NOW(a_status_last, m_axis_tvalid && m_axis_tuser != qsu_pkg::STATUS_DATA, m_axis_tlast, "status word without last")

	`QSU_ASSERT_NOW(a_status_zero_byte, m_axis_tvalid && m_axis_tuser != qsu_pkg::STATUS_DATA, m_axis_tdata[7:0] == 8'h00, "status word carries a byte")

	`QSU_ASSERT_NOW(a_err_matches, m_axis_tvalid, (m_axis_tuser == qsu_pkg::STATUS_ERROR) == (m_axis_tdata[10:8] != qsu_pkg::ERR_NONE), "error code disagrees with status")

	`QSU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

endmodule

bind quoted_string_unescape_utf8_unit qsu_checker u_qsu_checker (.*);

`default_nettype wire

### tb/tb_quoted_string_unescape_utf8_unit.sv
module tb_quoted_string_unescape_utf8_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 150;
	localparam int IDLE_PCT = 13;

	localparam logic [7:0] SIMPLE_ESC [8] = '{qsu_pkg::CH_DQUOTE, qsu_pkg::CH_BSLASH,
		qsu_pkg::ESC_N, qsu_pkg::ESC_T, qsu_pkg::ESC_R, qsu_pkg::ESC_B, qsu_pkg::ESC_F,
		qsu_pkg::ESC_ZERO};

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_LITERAL = 5'b00010,
		ST_BASIC   = 5'b00100,
		ST_ESCAPE  = 5'b01000,
		ST_HEX     = 5'b10000
	} scan_state_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		qsu_pkg::status_t status;
		logic [2:0]       err;
		logic             is_last;
	} dec_word_t;

	typedef struct packed {
		logic [7:0]       text;
		logic             eot;
		logic             typed;
		logic [7:0]       exp_byte;
		qsu_pkg::status_t exp_status;
		logic [2:0]       exp_err;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] text_byte
	logic        s_axis_tlast;   // end_of_text
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;   // [7:0] out_byte, [10:8] error_code
	logic [1:0]  m_axis_tuser;   // [1:0] status
	logic        m_axis_tlast;   // last

	scan_state_t scan_state;
	logic [3:0]  digits_left;
	logic [31:0] code_point;
	dec_word_t   pending_words [$];
	logic [8:0]  text_run [$];   // {end_of_text, text_byte}
	stim_row_t   directed_rows [27];
	bit          quiet;
	bit          failed = 1'b0;
	int          cycle_count = 0;
	int          random_items;

	quoted_string_unescape_utf8_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void push_word(logic [7:0] b, qsu_pkg::status_t st, logic [2:0] e);
		dec_word_t w;
		w.out_byte = b;
		w.status = st;
		w.err = e;
		w.is_last = 1'b0;
		pending_words.insert(pending_words.size(), w);
	endfunction

	function automatic void add_text(logic eot, logic [7:0] b);
		text_run.insert(text_run.size(), {eot, b});
	endfunction

	function automatic void abort_string(logic [2:0] e);
		scan_state = ST_IDLE;
		digits_left = 4'd0;
		code_point = 32'd0;
		push_word(8'h00, qsu_pkg::STATUS_ERROR, e);
	endfunction

	function automatic logic [4:0] hex_digit(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
		if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
			return {1'b1, c[3:0] + 4'd9};
		return 5'd0;
	endfunction

	// Lead bytes keep only their low eight bits, so code points beyond the
	// UTF-8 range still come out in the four-byte form.
	function automatic void emit_utf8(logic [31:0] cp);
		if (cp < 32'h80) begin
			push_word(cp[7:0], qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
		end else if (cp < 32'h800) begin
			push_word({3'b110, cp[10:6]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[5:0]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
		end else if (cp < 32'h10000) begin
			push_word({4'b1110, cp[15:12]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[11:6]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[5:0]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
		end else begin
			push_word(8'hF0 | cp[25:18], qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[17:12]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[11:6]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
			push_word({2'b10, cp[5:0]}, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
		end
	endfunction

	// Advances the decoder by one text byte and returns how many words it queued.
	function automatic int decode_byte(logic [7:0] c, logic eot);
		int unsigned base_n;
		logic [4:0] nib;
		base_n = pending_words.size();
		case (scan_state)
			ST_LITERAL: begin
				if (eot || c == qsu_pkg::CH_LF) begin
					abort_string(qsu_pkg::ERR_UNTERM_STR);
				end else if (c == qsu_pkg::CH_SQUOTE) begin
					scan_state = ST_IDLE;
					push_word(8'h00, qsu_pkg::STATUS_CLOSED, qsu_pkg::ERR_NONE);
				end else begin
					push_word(c, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
				end
			end
			ST_BASIC: begin
				if (eot || c == qsu_pkg::CH_LF) begin
					abort_string(qsu_pkg::ERR_UNTERM_STR);
				end else if (c == qsu_pkg::CH_DQUOTE) begin
					scan_state = ST_IDLE;
					push_word(8'h00, qsu_pkg::STATUS_CLOSED, qsu_pkg::ERR_NONE);
				end else if (c == qsu_pkg::CH_BSLASH) begin
					scan_state = ST_ESCAPE;
				end else begin
					push_word(c, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
				end
			end
			ST_ESCAPE: begin
				if (eot) begin
					abort_string(qsu_pkg::ERR_UNTERM_ESC);
				end else begin
					scan_state = ST_BASIC;
					case (c)
						qsu_pkg::CH_DQUOTE:
							push_word(qsu_pkg::CH_DQUOTE, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::CH_BSLASH:
							push_word(qsu_pkg::CH_BSLASH, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_N:
							push_word(qsu_pkg::CH_LF, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_T:
							push_word(8'h09, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_R:
							push_word(8'h0D, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_B:
							push_word(8'h08, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_F:
							push_word(8'h0C, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_ZERO:
							push_word(8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE);
						qsu_pkg::ESC_U4: begin
							scan_state = ST_HEX;
							digits_left = 4'd4;
							code_point = 32'd0;
						end
						qsu_pkg::ESC_U8: begin
							scan_state = ST_HEX;
							digits_left = 4'd8;
							code_point = 32'd0;
						end
						default: abort_string(qsu_pkg::ERR_BAD_ESC);
					endcase
				end
			end
			ST_HEX: begin
				nib = hex_digit(c);
				if (eot) begin
					abort_string(qsu_pkg::ERR_TRUNC_UNI);
				end else if (!nib[4]) begin
					abort_string(qsu_pkg::ERR_BAD_HEX);
				end else begin
					code_point = {code_point[27:0], nib[3:0]};
					digits_left = digits_left - 4'd1;
					if (digits_left == 4'd0) begin
						scan_state = ST_BASIC;
						emit_utf8(code_point);
					end
				end
			end
			default: begin
				if (!eot) begin
					scan_state = (c == qsu_pkg::CH_SQUOTE) ? ST_LITERAL : ST_BASIC;
					digits_left = 4'd0;
					code_point = 32'd0;
				end
			end
		endcase
		if (pending_words.size() > base_n)
			pending_words[pending_words.size() - 1].is_last = 1'b1;
		return pending_words.size() - base_n;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return $urandom_range(0, 1) ? 8'h57 + n : 8'h37 + n;
	endfunction

	function automatic logic [7:0] plain_byte(logic [7:0] closer);
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == qsu_pkg::CH_LF || c == closer || c == qsu_pkg::CH_BSLASH);
		return c;
	endfunction

	// Code points are drawn per UTF-8 length class so that every form shows up.
	function automatic void add_hex_escape();
		bit wide;
		logic [31:0] cp;
		int ndig;
		wide = ($urandom_range(0, 1) == 1);
		case ($urandom_range(0, wide ? 5 : 2))
			0: cp = $urandom_range(0, 'h7F);
			1: cp = $urandom_range('h80, 'h7FF);
			2: cp = $urandom_range('h800, 'hFFFF);
			3: cp = $urandom_range('h10000, 'h10FFFF);
			4: cp = $urandom;
			default: cp = 32'hFFFF_FFFF;
		endcase
		ndig = wide ? 8 : 4;
		add_text(1'b0, qsu_pkg::CH_BSLASH);
		add_text(1'b0, wide ? qsu_pkg::ESC_U8 : qsu_pkg::ESC_U4);
		for (int i = ndig - 1; i >= 0; i--)
			add_text(1'b0, hex_char(cp[4 * i +: 4]));
	endfunction

	function automatic void build_string();
		bit literal;
		int body_len;
		int pick;
		logic [7:0] opener;
		literal = ($urandom_range(0, 3) == 0);
		body_len = $urandom_range(0, 6);
		if (literal) begin
			opener = qsu_pkg::CH_SQUOTE;
		end else if ($urandom_range(0, 3) == 0) begin
			// Any byte but an apostrophe opens a basic string.
			do
				opener = 8'($urandom_range(0, 255));
			while (opener == qsu_pkg::CH_SQUOTE);
		end else begin
			opener = qsu_pkg::CH_DQUOTE;
		end
		add_text(1'b0, opener);
		for (int i = 0; i < body_len; i++) begin
			pick = $urandom_range(0, 9);
			if (literal) begin
				do
					opener = 8'($urandom_range(0, 255));
				while (opener == qsu_pkg::CH_LF || opener == qsu_pkg::CH_SQUOTE);
				add_text(1'b0, opener);
			end else if (pick < 5) begin
				add_text(1'b0, plain_byte(qsu_pkg::CH_DQUOTE));
			end else if (pick < 8) begin
				add_text(1'b0, qsu_pkg::CH_BSLASH);
				add_text(1'b0, SIMPLE_ESC[3'($urandom_range(0, 7))]);
			end else begin
				add_hex_escape();
			end
		end
		add_text(1'b0, literal ? qsu_pkg::CH_SQUOTE : qsu_pkg::CH_DQUOTE);
	endfunction

	task automatic send_word(input logic [7:0] b, input logic eot, output bit ignored,
			output int added);
		while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= eot;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		ignored = (scan_state == ST_IDLE) && eot;
		added = decode_byte(b, eot);
		@(negedge clk);
	endtask

	always @(negedge clk) begin
		m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	always @(posedge clk) begin
		dec_word_t exp_w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_words.size() == 0) begin
				$display("%0t: unexpected word, expected none, got byte %h status %0d err %0d",
					$time, m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[10:8]);
				failed = 1'b1;
			end else begin
				exp_w = pending_words.pop_front();
				if (m_axis_tdata[7:0] !== exp_w.out_byte) begin
					$display("%0t: out_byte expected %h, got %h",
						$time, exp_w.out_byte, m_axis_tdata[7:0]);
					failed = 1'b1;
				end
				if (m_axis_tuser !== exp_w.status) begin
					$display("%0t: status expected %0d, got %0d",
						$time, exp_w.status, m_axis_tuser);
					failed = 1'b1;
				end
				if (m_axis_tdata[10:8] !== exp_w.err) begin
					$display("%0t: error_code expected %0d, got %0d",
						$time, exp_w.err, m_axis_tdata[10:8]);
					failed = 1'b1;
				end
				if (m_axis_tlast !== exp_w.is_last) begin
					$display("%0t: last expected %b, got %b",
						$time, exp_w.is_last, m_axis_tlast);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, pending_words.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		bit ignored;
		int added;
		int pick;
		int idx;
		dec_word_t typed_w;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		s_axis_tlast = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		random_items = 0;
		scan_state = ST_IDLE;
		digits_left = 4'd0;
		code_point = 32'd0;

		directed_rows = '{
			'{8'h00, 1'b1, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE}, // ignored
			'{qsu_pkg::CH_SQUOTE, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'hFF, 1'b0, 1'b1, 8'hFF, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h00, 1'b0, 1'b1, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_LF, 1'b0, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR,
				qsu_pkg::ERR_UNTERM_STR},
			'{qsu_pkg::CH_DQUOTE, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h0D, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::ESC_N, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::ESC_U4, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h67, 1'b0, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR, qsu_pkg::ERR_BAD_HEX},
			'{8'h00, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h71, 1'b0, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR, qsu_pkg::ERR_BAD_ESC},
			'{8'hFF, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h00, 1'b1, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR, qsu_pkg::ERR_UNTERM_ESC},
			'{qsu_pkg::CH_DQUOTE, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_BSLASH, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::ESC_U8, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h41, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'h00, 1'b1, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR, qsu_pkg::ERR_TRUNC_UNI},
			'{8'h41, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_DQUOTE, 1'b0, 1'b1, 8'h00, qsu_pkg::STATUS_CLOSED,
				qsu_pkg::ERR_NONE},
			'{qsu_pkg::CH_SQUOTE, 1'b0, 1'b0, 8'h00, qsu_pkg::STATUS_DATA, qsu_pkg::ERR_NONE},
			'{8'hFF, 1'b1, 1'b1, 8'h00, qsu_pkg::STATUS_ERROR, qsu_pkg::ERR_UNTERM_STR}
		};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The results of one word cannot leave the block before the next edge,
		// so the words just queued by the predictor are still at the back.
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].text, directed_rows[i].eot, ignored, added);
			if (directed_rows[i].typed) begin
				repeat (added) void'(pending_words.pop_back());
				typed_w.out_byte = directed_rows[i].exp_byte;
				typed_w.status = directed_rows[i].exp_status;
				typed_w.err = directed_rows[i].exp_err;
				typed_w.is_last = 1'b1;
				pending_words.insert(pending_words.size(), typed_w);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			text_run.delete();
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				repeat ($urandom_range(1, 3))
					add_text($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
			end else begin
				build_string();
				if (pick < 25) begin
					idx = $urandom_range(1, text_run.size() - 1);
					case ($urandom_range(0, 2))
						0: text_run[idx] = {1'b0, qsu_pkg::CH_LF};
						1: text_run[idx] = {1'b1, 8'($urandom_range(0, 255))};
						default: text_run[idx] = {1'b0, 8'($urandom_range(0, 255))};
					endcase
					if ($urandom_range(0, 1))
						while (text_run.size() > idx + 1)
							void'(text_run.pop_back());
					// An end of text brings the decoder back to idle from any state.
					add_text(1'b1, 8'($urandom_range(0, 255)));
				end
			end
			foreach (text_run[i]) begin
				send_word(text_run[i][7:0], text_run[i][8], ignored, added);
				if (!ignored)
					random_items++;
				quiet = (random_items >= 60 && random_items < 110);
			end
		end
		s_axis_tvalid <= 1'b0;
		quiet = 1'b0;

		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failed)
			$display("== FAIL ==");
		else
			$display("== PASS ==");
		$finish;
	end

endmodule
